// ===== hw/rtl/ballistic_launch_angle_unit_macros.svh =====
// assertion macros for the ballistic launch angle unit
`ifndef BALLISTIC_LAUNCH_ANGLE_UNIT_MACROS_SVH
`define BALLISTIC_LAUNCH_ANGLE_UNIT_MACROS_SVH

// same-cycle implication
`define BLA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BLA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/bla_pkg.sv =====
// shared types and constants of the ballistic launch angle unit
`default_nettype none
package bla_pkg;

   localparam int WIDE_W      = 120;
   localparam int ROOT_BITS   = 60;
   localparam int REM_W       = ROOT_BITS + 3;
   localparam int VEC_W       = 64;
   localparam int SPEED_W     = 16;
   localparam int GBIG_W      = 26;
   localparam int V2_W        = 32;
   localparam int V4_W        = 64;
   localparam int LO_W        = 30;
   localparam int ANGLE_W     = 16;
   localparam int ACC_W       = 32;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int MAX_STEPS   = 24;
   localparam int NORM_MSB    = 58;
   localparam int NORM_STAGES = 3;
   localparam int FRONT_STAGES = 7;
   localparam int T0_SHIFT    = 24;
   localparam int T2_SHIFT    = 13;
   localparam int NUM_SHIFT   = 12;
   localparam int ROUND_SHIFT = 8;
   localparam int ROUND_HALF  = 128;
   localparam int GRAV_MULT   = 980;
   localparam int GSCALE_RESET = 4096;
   localparam int VERT_ANGLE  = 5120;
   localparam int RIGHT_ANGLE = 23040;
   localparam int ACC_MAX     = 5898240;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LAUNCH_SPEED    = 4'd0,
      REG_GRAVITY_SCALE   = 4'd1,
      REG_HIGH_ARC        = 4'd2,
      REG_VERTICAL_LAUNCH = 4'd3
   } csr_reg_type;

   typedef struct packed {
      logic reach;
      logic nneg;
      logic den_zero;
      logic num_zero;
   } side_type;

   // atan(2^-i) in 1/65536 degree
   function automatic logic signed [ACC_W-1:0] step_angle(input logic [4:0] idx);
      logic signed [ACC_W-1:0] a;
      unique case (idx)
         5'd0:  a = ACC_W'(2949120);
         5'd1:  a = ACC_W'(1740967);
         5'd2:  a = ACC_W'(919879);
         5'd3:  a = ACC_W'(466945);
         5'd4:  a = ACC_W'(234379);
         5'd5:  a = ACC_W'(117304);
         5'd6:  a = ACC_W'(58666);
         5'd7:  a = ACC_W'(29335);
         5'd8:  a = ACC_W'(14668);
         5'd9:  a = ACC_W'(7334);
         5'd10: a = ACC_W'(3667);
         5'd11: a = ACC_W'(1833);
         5'd12: a = ACC_W'(917);
         5'd13: a = ACC_W'(458);
         5'd14: a = ACC_W'(229);
         5'd15: a = ACC_W'(115);
         5'd16: a = ACC_W'(57);
         5'd17: a = ACC_W'(29);
         5'd18: a = ACC_W'(14);
         5'd19: a = ACC_W'(7);
         5'd20: a = ACC_W'(4);
         5'd21: a = ACC_W'(2);
         5'd22: a = ACC_W'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bla_channels.sv =====
// handshake channel interfaces of the ballistic launch angle unit
`default_nettype none
interface bla_req_if #(parameter int COORD_BITS = 24) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] target_x;
   logic signed [COORD_BITS-1:0] target_y;
   logic signed [COORD_BITS-1:0] target_z;
   logic signed [COORD_BITS-1:0] muzzle_x;
   logic signed [COORD_BITS-1:0] muzzle_y;
   logic signed [COORD_BITS-1:0] muzzle_z;
   modport source (output valid, target_x, target_y, target_z,
                   muzzle_x, muzzle_y, muzzle_z, input ready);
   modport sink (input valid, target_x, target_y, target_z,
                 muzzle_x, muzzle_y, muzzle_z, output ready);
endinterface

interface bla_rsp_if import bla_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] elevation_angle;
   logic                      in_reach;
   modport source (output valid, elevation_angle, in_reach, input ready);
   modport sink (input valid, elevation_angle, in_reach, output ready);
endinterface

interface bla_csr_if import bla_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bla_sqrt_pipe.sv =====
// pipelined integer square root, one result bit per stage
`default_nettype none
module bla_sqrt_pipe import bla_pkg::*; (
   input  wire logic                 clock,
   input  wire logic [ROOT_BITS-1:0] step_en,
   input  wire logic [WIDE_W-1:0]    radicand,
   output logic      [ROOT_BITS-1:0] root
);

   logic [REM_W-1:0]     rem_ff   [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff  [ROOT_BITS];
   logic [WIDE_W-1:0]    bits_ff  [ROOT_BITS];
   logic [REM_W-1:0]     rem_prev [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_prev[ROOT_BITS];
   logic [WIDE_W-1:0]    bits_prev[ROOT_BITS];

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_step
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic             take;

      if (j == 0) begin : g_first
         assign rem_prev[j]  = '0;
         assign root_prev[j] = '0;
         assign bits_prev[j] = radicand;
      end else begin : g_next
         assign rem_prev[j]  = rem_ff[j-1];
         assign root_prev[j] = root_ff[j-1];
         assign bits_prev[j] = bits_ff[j-1];
      end

      // bring down two bits, try root*4+1
      assign rem_sh = {rem_prev[j][REM_W-3:0], bits_prev[j][WIDE_W-1 -: 2]};
      assign trial  = REM_W'({root_prev[j], 2'b01});
      assign take   = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (step_en[j]) begin
            rem_ff[j]  <= take ? (rem_sh - trial) : rem_sh;
            root_ff[j] <= {root_prev[j][ROOT_BITS-2:0], take};
            bits_ff[j] <= bits_prev[j] << 2;
         end
      end
   end

   assign root = root_ff[ROOT_BITS-1];

endmodule
`default_nettype wire

// ===== hw/rtl/ballistic_launch_angle_unit.sv =====
// top level of the ballistic launch angle unit
//
// channel   dir  handshake     payload
// req_chan  in   valid/ready   target_x/y/z, muzzle_x/y/z (COORD_BITS, signed)
// rsp_chan  out  valid/ready   elevation_angle (16 signed, 1/256 deg), in_reach
// csr_chan  in   valid/ready   index (4), data (16); ready is always high
//
// one transfer per cycle in and out unless a full pipeline meets a stalled output
// most of the depth is in the parallel 60-stage square roots and the cordic steps
// synchronous active-high reset empties every stage and restores the registers
// a stage advances when it or any later stage is empty or the output is taken, so
// bubbles close up and a stalled output holds without losing or repeating items
`default_nettype none
`include "ballistic_launch_angle_unit_macros.svh"
module ballistic_launch_angle_unit import bla_pkg::*; #(
   parameter int COORD_BITS = 24,
   parameter int ATAN_STEPS = 16
) (
   input wire logic clock,
   input wire logic reset,
   bla_req_if.sink  req_chan,
   bla_rsp_if.source rsp_chan,
   bla_csr_if.sink  csr_chan
);

   localparam int DW     = COORD_BITS + 1;
   localparam int GA_W   = DW + GBIG_W;
   localparam int HI_W   = GA_W - LO_W;
   localparam int NSTEPS = (ATAN_STEPS > MAX_STEPS) ? MAX_STEPS : ATAN_STEPS;
   localparam int ST_Q0  = FRONT_STAGES;
   localparam int ST_N   = ST_Q0 + ROOT_BITS;
   localparam int ST_M0  = ST_N + 1;
   localparam int ST_C0  = ST_M0 + NORM_STAGES;
   localparam int ST_O   = ST_C0 + NSTEPS;
   localparam int NST    = ST_O + 1;

   // ---------------- configuration registers ----------------
   // speed and gravity are kept as v^2 and g (Q.12), formed at the write
   logic [V2_W-1:0]   v2_ff;
   logic [GBIG_W-1:0] big_g_ff;
   logic              high_arc_ff;
   logic              vertical_ff;
   logic              csr_wr;

   assign csr_chan.ready = 1'b1;
   assign csr_wr = csr_chan.valid & csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff       <= '0;
         big_g_ff    <= GBIG_W'(GRAV_MULT * GSCALE_RESET);
         high_arc_ff <= 1'b0;
         vertical_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_reg_type'(csr_chan.index))
            REG_LAUNCH_SPEED:    v2_ff <= V2_W'(csr_chan.data) * V2_W'(csr_chan.data);
            REG_GRAVITY_SCALE:   big_g_ff <= GBIG_W'(GBIG_W'(GRAV_MULT) *
                                                     GBIG_W'(csr_chan.data));
            REG_HIGH_ARC:        high_arc_ff <= csr_chan.data[0];
            REG_VERTICAL_LAUNCH: vertical_ff <= csr_chan.data[0];
            default: ;  // unknown index, dropped
         endcase
      end
   end

   // ---------------- stage valids and advance ----------------
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] en;

   for (genvar i = 0; i < NST; i++) begin : g_en
      assign en[i] = rsp_chan.ready | ~(&vld_ff[NST-1:i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= req_chan.valid;
         for (int i = 1; i < NST; i++) begin
            if (en[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   assign req_chan.ready = en[0];

   // ---------------- front: distances ----------------
   logic signed [DW-1:0] dx, dy, dz;
   logic [DW-1:0]        adx_in, ady_in, ah_in;
   logic [DW-1:0]        adx_ff, ady_ff, ah_ff;
   logic                 hneg1_ff;

   always_comb begin
      dx = {req_chan.target_x[COORD_BITS-1], req_chan.target_x} -
           {req_chan.muzzle_x[COORD_BITS-1], req_chan.muzzle_x};
      dy = {req_chan.target_y[COORD_BITS-1], req_chan.target_y} -
           {req_chan.muzzle_y[COORD_BITS-1], req_chan.muzzle_y};
      dz = {req_chan.target_z[COORD_BITS-1], req_chan.target_z} -
           {req_chan.muzzle_z[COORD_BITS-1], req_chan.muzzle_z};
      adx_in = dx[DW-1] ? DW'(-dx) : DW'(dx);
      ady_in = dy[DW-1] ? DW'(-dy) : DW'(dy);
      ah_in  = dz[DW-1] ? DW'(-dz) : DW'(dz);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         adx_ff   <= adx_in;
         ady_ff   <= ady_in;
         ah_ff    <= ah_in;
         hneg1_ff <= dz[DW-1];
      end
   end

   // scale by g, and v^4
   logic [GA_W-1:0] ga_ff, gb_ff, gh_ff;
   logic [V4_W-1:0] v4_ff, v4b_ff;
   logic            hneg2_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         ga_ff    <= GA_W'(big_g_ff) * GA_W'(adx_ff);
         gb_ff    <= GA_W'(big_g_ff) * GA_W'(ady_ff);
         gh_ff    <= GA_W'(big_g_ff) * GA_W'(ah_ff);
         v4_ff    <= V4_W'(v2_ff) * V4_W'(v2_ff);
         hneg2_ff <= hneg1_ff;
      end
   end

   // partial products of the wide squares and of g*h*v^2
   logic [2*HI_W-1:0]      a_hh_ff, b_hh_ff;
   logic [HI_W+LO_W-1:0]   a_hl_ff, b_hl_ff;
   logic [2*LO_W-1:0]      a_ll_ff, b_ll_ff;
   logic [HI_W+V2_W-1:0]   h_hi_ff;
   logic [LO_W+V2_W-1:0]   h_lo_ff;
   logic                   hneg3_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         a_hh_ff  <= (2*HI_W)'(ga_ff[GA_W-1:LO_W]) * (2*HI_W)'(ga_ff[GA_W-1:LO_W]);
         a_hl_ff  <= (HI_W+LO_W)'(ga_ff[GA_W-1:LO_W]) * (HI_W+LO_W)'(ga_ff[LO_W-1:0]);
         a_ll_ff  <= (2*LO_W)'(ga_ff[LO_W-1:0]) * (2*LO_W)'(ga_ff[LO_W-1:0]);
         b_hh_ff  <= (2*HI_W)'(gb_ff[GA_W-1:LO_W]) * (2*HI_W)'(gb_ff[GA_W-1:LO_W]);
         b_hl_ff  <= (HI_W+LO_W)'(gb_ff[GA_W-1:LO_W]) * (HI_W+LO_W)'(gb_ff[LO_W-1:0]);
         b_ll_ff  <= (2*LO_W)'(gb_ff[LO_W-1:0]) * (2*LO_W)'(gb_ff[LO_W-1:0]);
         h_hi_ff  <= (HI_W+V2_W)'(gh_ff[GA_W-1:LO_W]) * (HI_W+V2_W)'(v2_ff);
         h_lo_ff  <= (LO_W+V2_W)'(gh_ff[LO_W-1:0]) * (LO_W+V2_W)'(v2_ff);
         v4b_ff   <= v4_ff;
         hneg3_ff <= hneg2_ff;
      end
   end

   // assemble the wide terms
   logic [WIDE_W-1:0] sqa_ff, sqb_ff, t2_ff, t0_ff;
   logic              hneg4_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         sqa_ff <= (WIDE_W'(a_hh_ff) << (2*LO_W)) + (WIDE_W'(a_hl_ff) << (LO_W+1)) +
                   WIDE_W'(a_ll_ff);
         sqb_ff <= (WIDE_W'(b_hh_ff) << (2*LO_W)) + (WIDE_W'(b_hl_ff) << (LO_W+1)) +
                   WIDE_W'(b_ll_ff);
         t2_ff  <= ((WIDE_W'(h_hi_ff) << LO_W) + WIDE_W'(h_lo_ff)) << T2_SHIFT;
         t0_ff  <= WIDE_W'(v4b_ff) << T0_SHIFT;
         hneg4_ff <= hneg3_ff;
      end
   end

   // g^2 d^2, and the g*h*v^2 term goes to whichever side its sign puts it
   logic [WIDE_W-1:0] s5_ff, pos5_ff, negt_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_ff   <= sqa_ff + sqb_ff;
         pos5_ff <= hneg4_ff ? (t0_ff + t2_ff) : t0_ff;
         negt_ff <= hneg4_ff ? '0 : t2_ff;
      end
   end

   logic [WIDE_W-1:0] s6_ff, pos6_ff, negs_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_ff   <= s5_ff;
         pos6_ff <= pos5_ff;
         negs_ff <= s5_ff + negt_ff;
      end
   end

   // discriminant and reach flag
   logic [WIDE_W-1:0] disc_ff, s7_ff;
   logic              reach7_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         reach7_ff <= (pos6_ff > negs_ff);
         disc_ff   <= pos6_ff - negs_ff;
         s7_ff     <= s6_ff;
      end
   end

   // ---------------- square roots ----------------
   logic [ROOT_BITS-1:0] root_d, root_s;
   logic [ROOT_BITS-1:0] reach_q_ff;

   bla_sqrt_pipe u_sqrt_disc (
      .clock    (clock),
      .step_en  (en[ST_Q0 +: ROOT_BITS]),
      .radicand (disc_ff),
      .root     (root_d)
   );

   bla_sqrt_pipe u_sqrt_dist (
      .clock    (clock),
      .step_en  (en[ST_Q0 +: ROOT_BITS]),
      .radicand (s7_ff),
      .root     (root_s)
   );

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_reach
      always_ff @(posedge clock) begin
         if (en[ST_Q0 + j]) begin
            reach_q_ff[j] <= (j == 0) ? reach7_ff : reach_q_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   // ---------------- numerator and denominator ----------------
   logic [VEC_W-1:0] v2q;
   logic [VEC_W-1:0] rd_ext, rs_ext;
   logic [VEC_W-1:0] num_in;
   logic             nneg_in;
   side_type         nside_in;
   logic [VEC_W-1:0] nx_ff, ny_ff;
   side_type         nside_ff;

   always_comb begin
      v2q    = VEC_W'(v2_ff) << NUM_SHIFT;
      rd_ext = VEC_W'(root_d);
      rs_ext = VEC_W'(root_s);
      nneg_in = 1'b0;
      priority if (high_arc_ff) begin
         num_in = v2q + rd_ext;
      end else if (v2q >= rd_ext) begin
         num_in = v2q - rd_ext;
      end else begin
         num_in  = rd_ext - v2q;
         nneg_in = 1'b1;
      end
      nside_in.reach    = reach_q_ff[ROOT_BITS-1];
      nside_in.nneg     = nneg_in;
      nside_in.den_zero = (rs_ext == '0);
      nside_in.num_zero = (num_in == '0);
   end

   always_ff @(posedge clock) begin
      if (en[ST_N]) begin
         nx_ff    <= rs_ext;
         ny_ff    <= num_in;
         nside_ff <= nside_in;
      end
   end

   // ---------------- normalize to bit 58, two shift steps a stage ----------------
   logic [VEC_W-1:0] mx_ff   [NORM_STAGES];
   logic [VEC_W-1:0] my_ff   [NORM_STAGES];
   side_type         mside_ff[NORM_STAGES];

   for (genvar m = 0; m < NORM_STAGES; m++) begin : g_norm
      localparam int K1 = 1 << (5 - 2*m);
      localparam int K2 = 1 << (4 - 2*m);
      logic [VEC_W-1:0] x0, y0, x1, y1, x2, y2;
      side_type         sd0;

      if (m == 0) begin : g_first
         assign x0  = nx_ff;
         assign y0  = ny_ff;
         assign sd0 = nside_ff;
      end else begin : g_next
         assign x0  = mx_ff[m-1];
         assign y0  = my_ff[m-1];
         assign sd0 = mside_ff[m-1];
      end

      always_comb begin
         if (((x0 | y0) >> (NORM_MSB + 1 - K1)) == '0) begin
            x1 = x0 << K1;
            y1 = y0 << K1;
         end else begin
            x1 = x0;
            y1 = y0;
         end
         if (((x1 | y1) >> (NORM_MSB + 1 - K2)) == '0) begin
            x2 = x1 << K2;
            y2 = y1 << K2;
         end else begin
            x2 = x1;
            y2 = y1;
         end
      end

      always_ff @(posedge clock) begin
         if (en[ST_M0 + m]) begin
            mx_ff[m]    <= x2;
            my_ff[m]    <= y2;
            mside_ff[m] <= sd0;
         end
      end
   end

   // ---------------- cordic vectoring, one step a stage ----------------
   logic [VEC_W-1:0]        cx_ff   [NSTEPS];
   logic [VEC_W-1:0]        cy_ff   [NSTEPS];
   logic                    cneg_ff [NSTEPS];
   logic signed [ACC_W-1:0] cacc_ff [NSTEPS];
   side_type                cside_ff[NSTEPS];

   for (genvar i = 0; i < NSTEPS; i++) begin : g_cordic
      logic [VEC_W-1:0]        xp, yp, tx, ty, x_in, y_in;
      logic                    negp, neg_in;
      logic signed [ACC_W-1:0] accp, acc_in;
      side_type                sdp;

      if (i == 0) begin : g_first
         assign xp   = mx_ff[NORM_STAGES-1];
         assign yp   = my_ff[NORM_STAGES-1];
         assign negp = 1'b0;
         assign accp = '0;
         assign sdp  = mside_ff[NORM_STAGES-1];
      end else begin : g_next
         assign xp   = cx_ff[i-1];
         assign yp   = cy_ff[i-1];
         assign negp = cneg_ff[i-1];
         assign accp = cacc_ff[i-1];
         assign sdp  = cside_ff[i-1];
      end

      always_comb begin
         tx     = xp >> i;
         ty     = yp >> i;
         acc_in = negp ? (accp - step_angle(5'(i))) : (accp + step_angle(5'(i)));
         if (yp >= tx) begin
            y_in   = yp - tx;
            neg_in = negp;
         end else begin
            y_in   = tx - yp;
            neg_in = ~negp;
         end
         x_in = xp + ty;
      end

      always_ff @(posedge clock) begin
         if (en[ST_C0 + i]) begin
            cx_ff[i]    <= x_in;
            cy_ff[i]    <= y_in;
            cneg_ff[i]  <= neg_in;
            cacc_ff[i]  <= acc_in;
            cside_ff[i] <= sdp;
         end
      end
   end

   // ---------------- clamp, round, sign, special cases ----------------
   side_type                fside;
   logic signed [ACC_W-1:0] acc_f, acc_clip;
   logic [ACC_W-1:0]        rnd;
   logic [ANGLE_W-1:0]      mag;
   logic [ANGLE_W-1:0]      angle_in;
   logic                    reach_in;
   logic [ANGLE_W-1:0]      angle_ff;
   logic                    reach_out_ff;

   // cx/cy of the last step are not needed beyond the angle sum
   always_comb begin
      fside = cside_ff[NSTEPS-1];
      acc_f = cacc_ff[NSTEPS-1];
      priority if (acc_f < 0) begin
         acc_clip = '0;
      end else if (acc_f > ACC_W'(ACC_MAX)) begin
         acc_clip = ACC_W'(ACC_MAX);
      end else begin
         acc_clip = acc_f;
      end
      rnd = ACC_W'(acc_clip) + ACC_W'(ROUND_HALF);
      // straight up or down: the angle follows the sign of the numerator
      if (fside.den_zero) begin
         mag = fside.num_zero ? '0 : ANGLE_W'(RIGHT_ANGLE);
      end else begin
         mag = rnd[ANGLE_W+ROUND_SHIFT-1:ROUND_SHIFT];
      end
      priority if (vertical_ff) begin
         angle_in = ANGLE_W'(VERT_ANGLE);
         reach_in = 1'b1;
      end else if (!fside.reach) begin
         angle_in = '0;
         reach_in = 1'b0;
      end else begin
         angle_in = fside.nneg ? ANGLE_W'(-mag) : mag;
         reach_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_O]) begin
         angle_ff     <= angle_in;
         reach_out_ff <= reach_in;
      end
   end

   assign rsp_chan.valid           = vld_ff[ST_O];
   assign rsp_chan.elevation_angle = $signed(angle_ff);
   assign rsp_chan.in_reach        = reach_out_ff;

   // ---------------- assertions ----------------
   `BLA_ASSERT_NOW(a_unreached_zero, clock, reset, rsp_chan.valid && !rsp_chan.in_reach, rsp_chan.elevation_angle == '0, "out of reach result with nonzero angle")
   `BLA_ASSERT_NOW(a_angle_range, clock, reset, rsp_chan.valid, (rsp_chan.elevation_angle <= RIGHT_ANGLE) && (rsp_chan.elevation_angle >= -RIGHT_ANGLE), "angle beyond ninety degrees")
   `BLA_ASSERT_NOW(a_full_stall, clock, reset, (&vld_ff) && !rsp_chan.ready, !req_chan.ready, "full pipeline took a transfer")
   `BLA_ASSERT_NEXT(a_first_stage_fill, clock, reset, req_chan.valid && req_chan.ready, vld_ff[0], "accepted transfer missing from first stage")

endmodule
`default_nettype wire
